// ===== sv/i2cbr_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbr_pkg
// Shared types and constants for the I2C bus recovery sequencer.
// ----------------------------------------------------------------------------
package i2cbr_pkg;

  localparam int unsigned HALF_W     = 10;
  localparam int unsigned TIMEOUT_W  = 20;
  localparam int unsigned SETTLE_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [HALF_W-1:0]    HALF_RST    = 10'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd300000;
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = 10'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF    = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_SETTLE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_WAIT_A = 11'b000_0000_0010,
    PH_HOLD_A = 11'b000_0000_0100,
    PH_WAIT_B = 11'b000_0000_1000,
    PH_HOLD_B = 11'b000_0001_0000,
    PH_LOW    = 11'b000_0010_0000,
    PH_HIGH   = 11'b000_0100_0000,
    PH_START1 = 11'b000_1000_0000,
    PH_START2 = 11'b001_0000_0000,
    PH_START3 = 11'b010_0000_0000,
    PH_SETTLE = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic scl_drive;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic success;
    logic soft_reset;
  } res_t;

endpackage

// ===== sv/i2cbr_if.sv =====
// ----------------------------------------------------------------------------
// i2cbr interfaces
// Tick input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cbr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic scl_level;
  logic sda_level;

  modport source (output valid, output start_req, output scl_level, output sda_level,
                  input ready);
  modport sink   (input valid, input start_req, input scl_level, input sda_level,
                  output ready);
endinterface

interface i2cbr_out_if;
  logic valid;
  logic ready;
  logic scl_drive;
  logic sda_drive;
  logic busy_res;
  logic done_res;
  logic success;
  logic soft_reset;

  modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                  output done_res, output success, output soft_reset, input ready);
  modport sink   (input valid, input scl_drive, input sda_drive, input busy_res,
                  input done_res, input success, input soft_reset, output ready);
endinterface

// ===== sv/i2cbr_core.sv =====
// ----------------------------------------------------------------------------
// i2cbr_core
// Recovery state machine, config registers and per-tick result generation.
// ----------------------------------------------------------------------------
module i2cbr_core #(
  parameter int unsigned ELAPSED_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [i2cbr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [i2cbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             tick,
  input  logic                             start_req,
  input  logic                             scl_level,
  input  logic                             sda_level,
  output i2cbr_pkg::res_t                  res
);

  localparam int unsigned CW = (ELAPSED_WIDTH > i2cbr_pkg::TIMEOUT_W) ?
                               ELAPSED_WIDTH : i2cbr_pkg::TIMEOUT_W;
  localparam int unsigned HW = i2cbr_pkg::HALF_W;

  logic [HW-1:0]                   half_r;
  logic [i2cbr_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [i2cbr_pkg::SETTLE_W-1:0]  settle_r;

  i2cbr_pkg::phase_t        phase_r, phase_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [HW-1:0]            pc_r, pc_nxt;
  logic                     scl_r, scl_nxt, sda_r, sda_nxt;

  logic [HW-1:0] hold_len;
  logic [HW:0]   pc_plus, hold_n;
  logic          hold_end, timed_out;
  logic          done, ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= i2cbr_pkg::HALF_RST;
      timeout_r <= i2cbr_pkg::TIMEOUT_RST;
      settle_r  <= i2cbr_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        i2cbr_pkg::CFG_HALF:    half_r    <= cfg_wdata[HW-1:0];
        i2cbr_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata[i2cbr_pkg::TIMEOUT_W-1:0];
        i2cbr_pkg::CFG_SETTLE:  settle_r  <= cfg_wdata[i2cbr_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // hold length: zero counts as one tick
  assign hold_len = (phase_r == i2cbr_pkg::PH_SETTLE) ? settle_r : half_r;
  assign hold_n   = (hold_len == '0) ? (HW+1)'(1) : {1'b0, hold_len};
  assign pc_plus  = {1'b0, pc_r} + (HW+1)'(1);
  assign hold_end = pc_plus >= hold_n;

  // elapsed count saturates; it runs on every busy tick before the checks
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + ELAPSED_WIDTH'(1);
  assign timed_out   = (CW'(elapsed_inc) > CW'(timeout_r)) || (&elapsed_inc);

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = (phase_r == i2cbr_pkg::PH_IDLE) ? elapsed_r : elapsed_inc;
    pc_nxt      = pc_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    done        = 1'b0;
    ok          = 1'b0;
    unique case (phase_r)
      i2cbr_pkg::PH_IDLE: begin
        if (start_req) begin
          scl_nxt     = 1'b1;
          sda_nxt     = 1'b1;
          elapsed_nxt = '0;
          phase_nxt   = i2cbr_pkg::PH_WAIT_A;
          pc_nxt      = '0;
        end
      end
      i2cbr_pkg::PH_WAIT_A, i2cbr_pkg::PH_WAIT_B: begin
        if (scl_level) begin
          phase_nxt = (phase_r == i2cbr_pkg::PH_WAIT_A) ? i2cbr_pkg::PH_HOLD_A
                                                        : i2cbr_pkg::PH_HOLD_B;
          pc_nxt    = '0;
        end else if (timed_out) begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          done      = 1'b1;
          phase_nxt = i2cbr_pkg::PH_IDLE;
          pc_nxt    = '0;
        end
      end
      i2cbr_pkg::PH_SETTLE: begin
        if (!scl_level) begin
          // activity on SCL: go round again
          phase_nxt = i2cbr_pkg::PH_WAIT_A;
          pc_nxt    = '0;
        end else if (hold_end) begin
          done      = 1'b1;
          ok        = 1'b1;
          phase_nxt = i2cbr_pkg::PH_IDLE;
          pc_nxt    = '0;
        end else begin
          pc_nxt = pc_plus[HW-1:0];
        end
      end
      i2cbr_pkg::PH_HOLD_A, i2cbr_pkg::PH_HIGH, i2cbr_pkg::PH_HOLD_B,
      i2cbr_pkg::PH_LOW, i2cbr_pkg::PH_START1, i2cbr_pkg::PH_START2,
      i2cbr_pkg::PH_START3: begin
        if (!hold_end) begin
          pc_nxt = pc_plus[HW-1:0];
        end else begin
          pc_nxt = '0;
          unique case (phase_r)
            i2cbr_pkg::PH_HOLD_B: begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cbr_pkg::PH_LOW;
            end
            i2cbr_pkg::PH_LOW: begin
              scl_nxt   = 1'b1;
              phase_nxt = i2cbr_pkg::PH_HIGH;
            end
            i2cbr_pkg::PH_START1: begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cbr_pkg::PH_START2;
            end
            i2cbr_pkg::PH_START2: begin
              scl_nxt   = 1'b1;
              phase_nxt = i2cbr_pkg::PH_START3;
            end
            i2cbr_pkg::PH_START3: begin
              sda_nxt   = 1'b1;
              phase_nxt = i2cbr_pkg::PH_SETTLE;
            end
            default: begin
              // end of a high phase: SDA low means another clock pulse
              if (!sda_level) begin
                phase_nxt = i2cbr_pkg::PH_WAIT_B;
              end else begin
                sda_nxt   = 1'b0;
                phase_nxt = i2cbr_pkg::PH_START1;
              end
            end
          endcase
        end
      end
      default: begin
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b1;
        phase_nxt = i2cbr_pkg::PH_IDLE;
        pc_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cbr_pkg::PH_IDLE;
      elapsed_r <= '0;
      pc_r      <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      pc_r      <= pc_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

  always_comb begin
    res.scl_drive  = scl_nxt;
    res.sda_drive  = sda_nxt;
    res.busy_res   = (phase_nxt != i2cbr_pkg::PH_IDLE);
    res.done_res   = done;
    res.success    = ok;
    res.soft_reset = ok;
  end

endmodule

// ===== sv/i2cbr_skid.sv =====
// ----------------------------------------------------------------------------
// i2cbr_skid
// Result register plus skid stage driving the result channel.
// ----------------------------------------------------------------------------
module i2cbr_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cbr_pkg::res_t     push_data,
  output logic                can_push,
  i2cbr_out_if.source         out_ch
);

  logic            out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  i2cbr_pkg::res_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  assign can_push = !skid_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (push) begin
      if (!out_v_r || out_ch.ready) begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_data;
      end else begin
        // result register stalled: park the new result
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end else if (out_v_r && out_ch.ready) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.scl_drive  = out_d_r.scl_drive;
  assign out_ch.sda_drive  = out_d_r.sda_drive;
  assign out_ch.busy_res   = out_d_r.busy_res;
  assign out_ch.done_res   = out_d_r.done_res;
  assign out_ch.success    = out_d_r.success;
  assign out_ch.soft_reset = out_d_r.soft_reset;

endmodule

// ===== sv/i2c_bus_recovery_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_bus_recovery_sequencer
// Bus-clear sequencer for a hung I2C bus, one time-base tick per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick per transfer: start_req plus sampled SCL/SDA levels.
//   out_ch returns exactly one result per tick: line drives, busy, done,
//   success and a soft_reset pulse for the controller.
//   cfg_we/cfg_idx/cfg_wdata write half period (0), timeout (1) and settle
//   window (2); write them only while no sequence is running.
// Output: results are registered; a stalled one waits in the skid entry.
// Throughput: one tick per cycle while in_ch.ready is high; the state update
//   is a single registered pass through the sequencer state machine.
// Stall: a result register plus one skid entry sit on the output; in_ch.ready
//   drops only once both hold untaken results, and no result is lost.
// Reset (rst_n, synchronous): idle, both lines released, counters cleared,
//   config registers back to 10 / 300000 / 50 ticks, output empty.
// ----------------------------------------------------------------------------
module i2c_bus_recovery_sequencer #(
  parameter int unsigned ELAPSED_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [i2cbr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [i2cbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  i2cbr_in_if.sink                         in_ch,
  i2cbr_out_if.source                      out_ch
);

  logic            tick;
  logic            can_push;
  i2cbr_pkg::res_t res;

  assign in_ch.ready = can_push;
  assign tick        = in_ch.valid && can_push;

  i2cbr_core #(
    .ELAPSED_WIDTH(ELAPSED_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .start_req (in_ch.start_req),
    .scl_level (in_ch.scl_level),
    .sda_level (in_ch.sda_level),
    .res       (res)
  );

  i2cbr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_data (res),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done with busy still set");

  a_success_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.success |-> out_ch.done_res)
    else $error("success without done");

  a_srst_matches_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.soft_reset == out_ch.success)
    else $error("soft_reset and success disagree");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !$past(out_ch.ready))
    else $error("input stalled with output not backed up");

endmodule
